// ===== sv/bpc_pkg.sv =====
// Shared types and constants of the barometric compensation block.
package bpc_pkg;

  // Serial multiplier operand and product widths
  localparam int unsigned MUL_A_W = 58;
  localparam int unsigned MUL_B_W = 26;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W);

  localparam int unsigned RAW_W = 24;
  localparam int unsigned VALUE_W = 26;

  localparam logic signed [31:0] TEMP_MIN = -32'sd2621440;
  localparam logic signed [31:0] TEMP_MAX = 32'sd5570560;
  localparam logic signed [40:0] PRES_MAX = 41'sd33554431;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_CAL_TEMP = 2'd0;
  localparam logic [1:0] REG_CAL_PA   = 2'd1;
  localparam logic [1:0] REG_CAL_PB   = 2'd2;
  localparam logic [1:0] REG_CAL_PC   = 2'd3;

  localparam logic OP_TEMP = 1'b0;
  localparam logic OP_PRES = 1'b1;

  typedef struct packed {
    logic [39:0] w_t;
    logic [47:0] w_a;
    logic [47:0] w_b;
    logic [31:0] w_c;
  } cal_t;

endpackage

// ===== sv/bpc_mul.sv =====
// Bit-serial signed multiplier, one bit of the second operand per cycle.
module bpc_mul import bpc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic                      done_o,
  output logic signed [MUL_P_W-1:0] prod_o
);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [MUL_CNT_W-1:0]      cnt_q, cnt_d;
  logic signed [MUL_P_W-1:0] mcand_q, mcand_d;
  logic signed [MUL_P_W-1:0] acc_q, acc_d;
  logic signed [MUL_B_W-1:0] b_q, b_d;
  logic                      last;

  assign last = (cnt_q == MUL_CNT_W'(MUL_B_W - 1));

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    b_d     = b_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      mcand_d = MUL_P_W'(a_i);
      acc_d   = '0;
      b_d     = b_i;
    end else if (busy_q) begin
      // The top bit of b weighs negative
      if (b_q[0]) begin
        acc_d = last ? acc_q - mcand_q : acc_q + mcand_q;
      end
      mcand_d = mcand_q <<< 1;
      b_d     = b_q >>> 1;
      cnt_d   = cnt_q + MUL_CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
    b_q     <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== sv/bpc_core.sv =====
// Product sequencer: steps the shared multiplier through the polynomial terms and saturates the result.
module bpc_core import bpc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cal_t                      cal_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      in_op_i,
  input  logic [RAW_W-1:0]          in_raw_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic                      res_kind_o,
  output logic signed [VALUE_W-1:0] res_value_o,
  output logic                      res_clip_o
);

  typedef enum logic [2:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_FIN, ST_OUT} state_e;

  typedef enum logic [4:0] {
    T_DT2, T_DD, T_DDT3,
    P_TT, P_Q2T, P_P6, P_P7, P_P8, P_P2, P_P3, P_P4, P_KP,
    P_P10, P_XP, P_XPP, P_P11, P_P11P, P_P11PP
  } step_e;

  state_e state_q;
  step_e  step_q;
  logic   op_q;
  logic signed [23:0] t_q;

  logic [RAW_W-1:0]   raw_q;
  logic signed [24:0] d_q, d_d;
  logic signed [29:0] q2_q, q2_d;
  logic signed [36:0] q3_q, q3_d;
  logic signed [51:0] k_q, k_d;
  logic signed [33:0] x_q, x_d;
  logic signed [57:0] tmp_q, tmp_d;
  logic signed [63:0] sum_q, sum_d;
  logic signed [VALUE_W-1:0] val_q, val_d;
  logic clip_q, clip_d;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      mul_done;
  logic signed [MUL_P_W-1:0] prod;
  logic                      accept;
  logic                      last_step;

  // Calibration fields
  logic [15:0]        t1, t2, p5, p6;
  logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
  logic signed [15:0] p1, p2, p9;
  logic signed [16:0] p1m, p2m;
  logic signed [25:0] praw;
  logic signed [31:0] tv;
  logic signed [40:0] pv;

  assign t1  = cal_i.w_t[15:0];
  assign t2  = cal_i.w_t[31:16];
  assign t3  = $signed(cal_i.w_t[39:32]);
  assign p1  = $signed(cal_i.w_a[15:0]);
  assign p2  = $signed(cal_i.w_a[31:16]);
  assign p3  = $signed(cal_i.w_a[39:32]);
  assign p4  = $signed(cal_i.w_a[47:40]);
  assign p5  = cal_i.w_b[15:0];
  assign p6  = cal_i.w_b[31:16];
  assign p7  = $signed(cal_i.w_b[39:32]);
  assign p8  = $signed(cal_i.w_b[47:40]);
  assign p9  = $signed(cal_i.w_c[15:0]);
  assign p10 = $signed(cal_i.w_c[23:16]);
  assign p11 = $signed(cal_i.w_c[31:24]);
  assign p1m = 17'(p1) - 17'sd16384;
  assign p2m = 17'(p2) - 17'sd16384;
  assign praw = $signed({2'b00, raw_q});

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o = (state_q == ST_IDLE);
  assign last_step  = (step_q == T_DDT3) || (step_q == P_P11PP);

  // Operand selection for each product
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      T_DT2:   begin mul_a = MUL_A_W'(d_q);   mul_b = $signed({10'd0, t2}); end
      T_DD:    begin mul_a = MUL_A_W'(d_q);   mul_b = MUL_B_W'(d_q);        end
      T_DDT3:  begin mul_a = tmp_q;           mul_b = MUL_B_W'(t3);         end
      P_TT:    begin mul_a = MUL_A_W'(t_q);   mul_b = MUL_B_W'(t_q);        end
      P_Q2T:   begin mul_a = MUL_A_W'(q2_q);  mul_b = MUL_B_W'(t_q);        end
      P_P6:    begin mul_a = MUL_A_W'(t_q);   mul_b = $signed({10'd0, p6}); end
      P_P7:    begin mul_a = MUL_A_W'(q2_q);  mul_b = MUL_B_W'(p7);         end
      P_P8:    begin mul_a = MUL_A_W'(q3_q);  mul_b = MUL_B_W'(p8);         end
      P_P2:    begin mul_a = MUL_A_W'(t_q);   mul_b = MUL_B_W'(p2m);        end
      P_P3:    begin mul_a = MUL_A_W'(q2_q);  mul_b = MUL_B_W'(p3);         end
      P_P4:    begin mul_a = MUL_A_W'(q3_q);  mul_b = MUL_B_W'(p4);         end
      P_KP:    begin mul_a = MUL_A_W'(k_q);   mul_b = praw;                 end
      P_P10:   begin mul_a = MUL_A_W'(t_q);   mul_b = MUL_B_W'(p10);        end
      P_XP:    begin mul_a = MUL_A_W'(x_q);   mul_b = praw;                 end
      P_XPP:   begin mul_a = tmp_q;           mul_b = praw;                 end
      P_P11:   begin mul_a = MUL_A_W'(p11);   mul_b = praw;                 end
      P_P11P:  begin mul_a = tmp_q;           mul_b = praw;                 end
      P_P11PP: begin mul_a = tmp_q;           mul_b = praw;                 end
      default: begin mul_a = '0;              mul_b = '0;                   end
    endcase
  end

  bpc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == ST_ISSUE),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (prod)
  );

  assign tv = 32'(sum_q >>> 32);
  assign pv = 41'(sum_q >>> 23);

  // Load the terms on acceptance, accumulate each finished product into its term, then saturate the result
  always_comb begin
    d_d   = d_q;
    q2_d  = q2_q;
    q3_d  = q3_q;
    k_d   = k_q;
    x_d   = x_q;
    tmp_d = tmp_q;
    sum_d = sum_q;
    val_d = val_q;
    clip_d = clip_q;
    if (accept) begin
      d_d   = $signed({1'b0, in_raw_i}) - $signed({1'b0, t1, 8'd0});
      sum_d = $signed({14'd0, p5, 34'd0});
      k_d   = 52'(p1m) <<< 33;
    end else if (state_q == ST_WAIT && mul_done) begin
      case (step_q)
        T_DT2:   sum_d = 64'(prod) <<< 18;
        T_DD:    tmp_d = 58'(prod);
        T_DDT3:  sum_d = sum_q + 64'(prod);
        P_TT:    q2_d  = 30'(prod >>> 16);
        P_Q2T:   q3_d  = 37'(prod >>> 16);
        P_P6:    sum_d = sum_q + (64'(prod) <<< 9);
        P_P7:    sum_d = sum_q + (64'(prod) <<< 7);
        P_P8:    sum_d = sum_q + 64'(prod);
        P_P2:    k_d   = k_q + (52'(prod) <<< 8);
        P_P3:    k_d   = k_q + (52'(prod) <<< 5);
        P_P4:    k_d   = k_q + 52'(prod);
        P_KP:    sum_d = sum_q + 64'(prod >>> 22);
        P_P10:   x_d   = (34'(p9) <<< 16) + 34'(prod);
        P_XP:    tmp_d = 58'(prod);
        P_XPP:   sum_d = sum_q + 64'(prod >>> 33);
        P_P11:   tmp_d = 58'(prod);
        P_P11P:  tmp_d = 58'(prod);
        P_P11PP: sum_d = sum_q + 64'(prod >>> 34);
        default: sum_d = sum_q;
      endcase
    end else if (state_q == ST_FIN) begin
      clip_d = 1'b0;
      if (op_q == OP_TEMP) begin
        val_d = VALUE_W'(tv);
        if (tv < TEMP_MIN) begin
          val_d  = VALUE_W'(TEMP_MIN);
          clip_d = 1'b1;
        end else if (tv > TEMP_MAX) begin
          val_d  = VALUE_W'(TEMP_MAX);
          clip_d = 1'b1;
        end
      end else begin
        val_d = VALUE_W'(pv);
        if (pv < 41'sd0) begin
          val_d  = '0;
          clip_d = 1'b1;
        end else if (pv > PRES_MAX) begin
          val_d  = VALUE_W'(PRES_MAX);
          clip_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= T_DT2;
      op_q    <= OP_TEMP;
      t_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q    <= in_op_i;
            step_q  <= (in_op_i == OP_PRES) ? P_TT : T_DT2;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (mul_done) begin
            if (last_step) begin
              state_q <= ST_FIN;
            end else begin
              step_q  <= step_e'(step_q + 5'd1);
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_FIN: begin
          // Keep the saturated temperature for later pressure samples
          if (op_q == OP_TEMP) begin
            t_q <= 24'(val_d);
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_q <= in_raw_i;
    end
    d_q    <= d_d;
    q2_q   <= q2_d;
    q3_q   <= q3_d;
    k_q    <= k_d;
    x_q    <= x_d;
    tmp_q  <= tmp_d;
    sum_q  <= sum_d;
    val_q  <= val_d;
    clip_q <= clip_d;
  end

  assign res_valid_o = (state_q == ST_OUT);
  assign res_kind_o  = op_q;
  assign res_value_o = val_q;
  assign res_clip_o  = clip_q;

endmodule

// ===== sv/baro_temp_pressure_compensation.sv =====
// Top level: calibration registers, stream ports and output register.
//
// One item is worked at a time. A temperature sample needs 3 products and a
// pressure sample 15, all on a single bit-serial 58x26 multiplier. A
// finished result sits in the output register, so the next sample is taken
// while it waits. Pressure uses the last compensated temperature, 0 degC
// after reset.
module baro_temp_pressure_compensation import bpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // raw_sample[23:0]
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // value[25:0], clipped[26], zero[31:27]
  output logic        m_axis_tuser    // kind
);

  cal_t cal_q;
  logic res_valid, res_ready, res_kind, res_clip;
  logic signed [VALUE_W-1:0] res_value;
  logic out_valid_q;
  logic out_kind_q, out_clip_q;
  logic [VALUE_W-1:0] out_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CAL_TEMP: cal_q.w_t <= cfg_data_i[39:0];
        REG_CAL_PA:   cal_q.w_a <= cfg_data_i;
        REG_CAL_PB:   cal_q.w_b <= cfg_data_i;
        REG_CAL_PC:   cal_q.w_c <= cfg_data_i[31:0];
        default:      cal_q     <= cal_q;
      endcase
    end
  end

  bpc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cal_i      (cal_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser),
    .in_raw_i   (s_axis_tdata),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_kind_o (res_kind),
    .res_value_o(res_value),
    .res_clip_o (res_clip)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_kind_q  <= res_kind;
      out_value_q <= res_value;
      out_clip_q  <= res_clip;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_clip_q, out_value_q};
  assign m_axis_tuser  = out_kind_q;

endmodule

// ===== sv/bpc_checker.sv =====
// Port-level checks of the compensation block, bound to the top level.
module bpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:27] == 5'd0)
    else $error("pad bits set");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      $signed(m_axis_tdata[25:0]) >= -26'sd2621440 &&
      $signed(m_axis_tdata[25:0]) <= 26'sd5570560)
    else $error("temperature out of range");

  a_pres_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[25] == 1'b0)
    else $error("negative pressure");

  a_temp_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser && m_axis_tdata[26] |->
      $signed(m_axis_tdata[25:0]) == -26'sd2621440 ||
      $signed(m_axis_tdata[25:0]) == 26'sd5570560)
    else $error("clipped temperature not at a limit");

endmodule

bind baro_temp_pressure_compensation bpc_checker u_bpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// ===== verif/baro_temp_pressure_compensation_chk.sv =====
// Checker: predicts compensated temperature and pressure and compares results.
module baro_temp_pressure_compensation_chk import bpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          pending_o,
  output int          errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic              kind;
    logic signed [25:0] value;
    logic              clipped;
  } reading_t;

  logic [39:0]        cal_temp;
  logic [47:0]        cal_pa;
  logic [47:0]        cal_pb;
  logic [31:0]        cal_pc;
  logic signed [31:0] held_temp;
  reading_t           expected_q[$];
  int                 errors;

  assign pending_o = expected_q.size();
  assign errors_o  = errors;

  function automatic reading_t compensate(logic op, logic [23:0] raw);
    wide_t t1, t2, t3, d, v, t, q2, q3, sum, praw;
    wide_t p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    reading_t r;
    r.kind    = op;
    r.clipped = 1'b0;
    praw      = raw;
    if (op == OP_TEMP) begin
      t1 = cal_temp[15:0];
      t2 = cal_temp[31:16];
      t3 = $signed(cal_temp[39:32]);
      d  = praw - (t1 <<< 8);
      v  = (((d * t2) <<< 18) + d * d * t3) >>> 32;
      if (v < TEMP_MIN) begin
        v = TEMP_MIN;
        r.clipped = 1'b1;
      end
      if (v > TEMP_MAX) begin
        v = TEMP_MAX;
        r.clipped = 1'b1;
      end
      held_temp = v[31:0];
    end else begin
      p1  = $signed(cal_pa[15:0]);
      p2  = $signed(cal_pa[31:16]);
      p3  = $signed(cal_pa[39:32]);
      p4  = $signed(cal_pa[47:40]);
      p5  = cal_pb[15:0];
      p6  = cal_pb[31:16];
      p7  = $signed(cal_pb[39:32]);
      p8  = $signed(cal_pb[47:40]);
      p9  = $signed(cal_pc[15:0]);
      p10 = $signed(cal_pc[23:16]);
      p11 = $signed(cal_pc[31:24]);
      t   = held_temp;
      q2  = (t * t) >>> 16;
      q3  = (q2 * t) >>> 16;
      // offset and sensitivity terms, then the raw pressure powers
      sum = (p5 <<< 34) + ((p6 * t) <<< 9) + ((p7 * q2) <<< 7) + p8 * q3;
      v   = ((p1 - 16384) <<< 33) + (((p2 - 16384) * t) <<< 8)
            + ((p3 * q2) <<< 5) + p4 * q3;
      sum = sum + ((v * praw) >>> 22);
      sum = sum + ((((p9 <<< 16) + p10 * t) * praw * praw) >>> 33);
      sum = sum + ((p11 * praw * praw * praw) >>> 34);
      v   = sum >>> 23;
      if (v < 0) begin
        v = 0;
        r.clipped = 1'b1;
      end
      if (v > PRES_MAX) begin
        v = PRES_MAX;
        r.clipped = 1'b1;
      end
    end
    r.value = v[25:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t exp_r;
    if (!rst_ni) begin
      cal_temp  = '0;
      cal_pa    = '0;
      cal_pb    = '0;
      cal_pc    = '0;
      held_temp = '0;
      errors    = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CAL_TEMP: cal_temp = cfg_data_i[39:0];
          REG_CAL_PA:   cal_pa   = cfg_data_i;
          REG_CAL_PB:   cal_pb   = cfg_data_i;
          REG_CAL_PC:   cal_pc   = cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result kind=%0b tdata=%h", $realtime,
                   m_axis_tuser, m_axis_tdata);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (m_axis_tuser !== exp_r.kind || m_axis_tdata[25:0] !== exp_r.value ||
              m_axis_tdata[26] !== exp_r.clipped || m_axis_tdata[31:27] !== 5'd0) begin
            $display("%0t: mismatch expected kind=%0b value=%0d clipped=%0b,",
                     $realtime, exp_r.kind, exp_r.value, exp_r.clipped,
                     " actual kind=%0b value=%0d clipped=%0b pad=%h",
                     m_axis_tuser, $signed(m_axis_tdata[25:0]), m_axis_tdata[26],
                     m_axis_tdata[31:27]);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(compensate(s_axis_tuser, s_axis_tdata));
    end
  end

endmodule

// ===== verif/baro_temp_pressure_compensation_tb.sv =====
// Testbench top: clock, reset, stimulus, calibration phases and verdict.
module baro_temp_pressure_compensation_tb import bpc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_CAL_TEMP;
  logic [47:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = OP_TEMP;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  int          pending;
  int          errors;
  logic        no_idle = 1'b0;
  logic        hold_req = 1'b0;
  int          quiet_cycles = 0;
  logic [15:0] t1_now = '0;

  always #6 clk_i = ~clk_i;

  baro_temp_pressure_compensation dut (.*);

  baro_temp_pressure_compensation_chk chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .pending_o(pending), .errors_o(errors)
  );

  // Receiver: random stalls, plus one long hold-off to back up the block.
  initial begin
    int w;
    bit held;
    held = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      w = no_idle ? 0 : $urandom_range(0, 19);
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("baro_temp_pressure_compensation_tb: FAIL");
      $finish;
    end
  end

  task automatic send_sample(logic op, logic [23:0] raw);
    int g;
    g = no_idle ? 0 : $urandom_range(0, 19);
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= raw;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Leave the write enable high; the caller drops it after the last write
  task automatic write_cal(logic [1:0] idx, logic [47:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic calibrate(int mode);
    logic [47:0] w;
    case (mode)
      0: begin
        w = '0;
        write_cal(REG_CAL_TEMP, w); write_cal(REG_CAL_PA, w);
        write_cal(REG_CAL_PB, w); write_cal(REG_CAL_PC, w);
      end
      1: begin
        w = '1;
        write_cal(REG_CAL_TEMP, w); write_cal(REG_CAL_PA, w);
        write_cal(REG_CAL_PB, w); write_cal(REG_CAL_PC, w);
      end
      2: begin
        // fully random words, upper bits included
        write_cal(REG_CAL_TEMP, 48'({$urandom, $urandom}));
        write_cal(REG_CAL_PA, 48'({$urandom, $urandom}));
        write_cal(REG_CAL_PB, 48'({$urandom, $urandom}));
        write_cal(REG_CAL_PC, 48'({$urandom, $urandom}));
      end
      default: begin
        // plausible sensor trim so most results stay in range
        t1_now = 16'($urandom_range(20000, 30000));
        write_cal(REG_CAL_TEMP, {8'hFF, 8'($urandom), 16'($urandom_range(15000, 25000)), t1_now});
        write_cal(REG_CAL_PA, {8'($urandom), 8'($urandom), 16'($urandom_range(0, 8000)),
                               16'($urandom_range(16384, 24000))});
        write_cal(REG_CAL_PB, {8'($urandom), 8'($urandom), 16'($urandom),
                               16'($urandom_range(1000, 30000))});
        write_cal(REG_CAL_PC, 48'({8'($urandom), 8'($urandom), 16'($urandom)}));
      end
    endcase
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [23:0] pick_raw(logic op);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'h000000;
    if (r == 1) return 24'hFFFFFF;
    if (r < 5 || op == OP_PRES) return 24'($urandom);
    return 24'((int'(t1_now) << 8) + $urandom_range(0, 2097152) - 1048576);
  endfunction

  initial begin
    logic op;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pressure before any temperature, all under the zero trim from reset
    send_sample(OP_PRES, 24'hFFFFFF);
    send_sample(OP_TEMP, 24'h000000);
    send_sample(OP_PRES, 24'h000000);
    drain();
    calibrate(3);
    send_sample(OP_PRES, 24'($urandom));
    send_sample(OP_TEMP, {t1_now, 8'h00});
    send_sample(OP_PRES, 24'h000000);
    send_sample(OP_PRES, 24'hFFFFFF);
    send_sample(OP_TEMP, 24'h000000);
    send_sample(OP_PRES, 24'h800000);
    send_sample(OP_TEMP, 24'hFFFFFF);
    send_sample(OP_PRES, 24'h7FFFFF);
    drain();
    calibrate(1);
    send_sample(OP_TEMP, 24'hFFFFFF);
    send_sample(OP_PRES, 24'hFFFFFF);
    send_sample(OP_TEMP, 24'h000000);
    send_sample(OP_PRES, 24'h555555);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      calibrate(ph == 0 ? 0 : ph == 4 ? 1 : ph == 6 ? 2 : 3);
      no_idle <= (ph % 3 == 2);
      if (ph == 3) hold_req <= 1'b1;
      for (int i = 0; i < 80; i++) begin
        op = logic'($urandom_range(0, 1));
        send_sample(op, pick_raw(op));
      end
      drain();
      no_idle <= 1'b0;
    end

    repeat (450) @(posedge clk_i);
    if (errors == 0)
      $display("baro_temp_pressure_compensation_tb: PASS");
    else
      $display("baro_temp_pressure_compensation_tb: FAIL");
    $finish;
  end

endmodule

// ===== baro_temp_pressure_compensation.f =====
sv/bpc_pkg.sv
sv/bpc_mul.sv
sv/bpc_core.sv
sv/baro_temp_pressure_compensation.sv
sv/bpc_checker.sv
verif/baro_temp_pressure_compensation_chk.sv
verif/baro_temp_pressure_compensation_tb.sv
